FILE: design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds
`define LCDT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cond must never hold
`define LCDT_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`endif

FILE: design/lcdt_pkg.sv
// ----------------------------------------------------------------------------
// lcdt_pkg
// Shared types and constants of the lcd dot timing controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdt_pkg;

  localparam int unsigned DotsW = 9;
  localparam int unsigned LineW = 8;
  localparam int unsigned StepW = 6;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [DotsW-1:0] DOTS_PER_LINE = 9'd456;
  localparam logic [DotsW-1:0] OAM_END_DOT   = 9'd80;
  localparam logic [DotsW-1:0] XFER_END_DOT  = 9'd252;
  localparam logic [LineW-1:0] VBLANK_LINE   = 8'd144;
  localparam logic [LineW-1:0] LAST_LINE     = 8'd153;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam int unsigned EN_HBLANK = 0;
  localparam int unsigned EN_VBLANK = 1;
  localparam int unsigned EN_OAM    = 2;
  localparam int unsigned EN_COINC  = 3;

  localparam logic [1:0] REG_LCD_ENABLE = 2'd0;
  localparam logic [1:0] REG_LYC        = 2'd1;
  localparam logic [1:0] REG_STAT_EN    = 2'd2;

  typedef struct packed {
    logic             lcd_enable;
    logic [LineW-1:0] lyc;
    logic [3:0]       stat_int_enables;
  } cfg_t;

  typedef struct packed {
    logic [StepW-1:0] dots;
    logic             clear_frame;
  } step_t;

  typedef struct packed {
    logic coin;
    logic irq;
  } cmp_t;

endpackage

`default_nettype wire

FILE: design/lcdt_in_if.sv
// ----------------------------------------------------------------------------
// lcdt_in_if
// Input channel: machine cycle count and frame clear.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdt_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] cycle_count;
  logic       clear_frame;

  modport source (output valid, output cycle_count, output clear_frame, input ready);
  modport sink (input valid, input cycle_count, input clear_frame, output ready);
endinterface

`default_nettype wire

FILE: design/lcdt_out_if.sv
// ----------------------------------------------------------------------------
// lcdt_out_if
// Result channel: timing state and events of one step.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line;
  logic [1:0] mode_out;
  logic       coincidence;
  logic       vblank_irq;
  logic       stat_irq;
  logic       render_start;
  logic [7:0] render_line;
  logic       frame_done;

  modport source (output valid, output line, output mode_out, output coincidence,
                  output vblank_irq, output stat_irq, output render_start,
                  output render_line, output frame_done, input ready);
  modport sink (input valid, input line, input mode_out, input coincidence,
                input vblank_irq, input stat_irq, input render_start,
                input render_line, input frame_done, output ready);
endinterface

`default_nettype wire

FILE: design/lcd_dot_timing_controller.sv
// ----------------------------------------------------------------------------
// lcd_dot_timing_controller
// Lcd dot and line timing with mode, status interrupts and render requests.
// ----------------------------------------------------------------------------
// Each accepted transaction advances the display by four dots per machine
// cycle, one dot per clock in the dot engine. For each transaction the
// engine takes it from the two-entry input queue, advances through its dots
// and then loads the output register; a result that is not taken holds the
// engine. The input queue takes up to two transactions while the engine runs
// and a result waits in the output register. Registers: 0x0 lcd_enable,
// 0x4 lyc, 0x8 stat_int_enables; write them only while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module lcd_dot_timing_controller (
  input  wire logic                       clk,
  input  wire logic                       rst,
  lcdt_in_if.sink                         in_ch,
  lcdt_out_if.source                      out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lcdt_pkg::AddrW-1:0] paddr,
  input  wire logic [lcdt_pkg::DataW-1:0] pwdata,
  output logic [lcdt_pkg::DataW-1:0]      prdata,
  output logic                            pready
);
  import lcdt_pkg::*;

  cfg_t  cfg;
  step_t q_item;
  logic  q_valid;
  logic  q_ready;
  logic  busy;

  lcdt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcdt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  lcdt_dot_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch),
    .busy    (busy)
  );

  `LCDT_ASSERT_NEVER(a_line_range, clk, rst, out_ch.valid && (out_ch.line > LAST_LINE))
  `LCDT_ASSERT_IMPLY(a_vblank_mode, clk, rst, out_ch.valid && (out_ch.line >= VBLANK_LINE), out_ch.mode_out == MODE_VBLANK)
  `LCDT_ASSERT_IMPLY(a_vblank_irq, clk, rst, out_ch.valid && out_ch.vblank_irq, (out_ch.line == VBLANK_LINE) && (out_ch.mode_out == MODE_VBLANK))
  `LCDT_ASSERT_IMPLY(a_render_line, clk, rst, out_ch.valid && !out_ch.render_start, out_ch.render_line == 8'd0)
  `LCDT_ASSERT_IMPLY(a_queue_busy, clk, rst, q_valid, busy)

endmodule

`default_nettype wire

FILE: design/lcdt_front.sv
// ----------------------------------------------------------------------------
// lcdt_front
// Accepts steps, converts machine cycles to dots and queues them (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none

module lcdt_front (
  input  wire logic           clk,
  input  wire logic           rst,
  lcdt_in_if.sink             in_ch,
  output logic                q_valid,
  input  wire logic           q_ready,
  output lcdt_pkg::step_t     q_item
);
  import lcdt_pkg::*;

  step_t      queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{dots: {in_ch.cycle_count, 2'b00}, clear_frame: in_ch.clear_frame};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/lcdt_dot_engine.sv
// ----------------------------------------------------------------------------
// lcdt_dot_engine
// Runs one dot per cycle for each queued step and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdt_dot_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lcdt_pkg::cfg_t cfg,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire lcdt_pkg::step_t q_item,
  lcdt_out_if.source          out_ch,
  output logic                busy
);
  import lcdt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state;
  logic [DotsW-1:0] dot_count;
  logic [LineW-1:0] line_count;
  logic [1:0]       current_mode;
  logic             coincidence_flag;
  logic             lcd_was_on;
  logic             frame_flag;
  logic [StepW-1:0] dots_left;
  logic             irq_stat;
  logic             irq_vblank;
  logic             rstart;
  logic [LineW-1:0] rline;

  logic             out_valid;
  logic [LineW-1:0] out_line;
  logic [1:0]       out_mode;
  logic             out_coin;
  logic             out_vbl;
  logic             out_stat;
  logic             out_rs;
  logic [LineW-1:0] out_rl;
  logic             out_frame;
  logic             out_free;

  logic [DotsW-1:0] dot_next;
  logic [LineW-1:0] line_next;
  logic [1:0]       mode_next;
  logic             coin_next;
  logic             was_on_next;
  logic             frame_next;
  logic             stat_hit;
  logic             vbl_hit;
  logic             rs_hit;
  logic [1:0]       nm;
  logic [DotsW-1:0] dot_inc;
  cmp_t             cmp;

  function automatic cmp_t compare_step(logic [LineW-1:0] l, logic [LineW-1:0] ref_l,
                                        logic coin, logic en);
    cmp_t r;
    r.coin = (l == ref_l);
    r.irq  = (l == ref_l) && !coin && en;
    return r;
  endfunction

  function automatic logic mode_irq(logic [1:0] m, logic [3:0] en);
    logic r;
    case (m)
      MODE_HBLANK: r = en[EN_HBLANK];
      MODE_VBLANK: r = en[EN_VBLANK];
      MODE_OAM:    r = en[EN_OAM];
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    dot_next    = dot_count;
    line_next   = line_count;
    mode_next   = current_mode;
    coin_next   = coincidence_flag;
    was_on_next = lcd_was_on;
    frame_next  = frame_flag;
    stat_hit    = 1'b0;
    vbl_hit     = 1'b0;
    rs_hit      = 1'b0;
    nm          = MODE_HBLANK;
    dot_inc     = '0;
    cmp         = '0;
    if (!cfg.lcd_enable) begin
      dot_next    = '0;
      line_next   = '0;
      mode_next   = MODE_HBLANK;
      was_on_next = 1'b0;
      frame_next  = 1'b0;
      cmp         = compare_step(line_next, cfg.lyc, coin_next, cfg.stat_int_enables[EN_COINC]);
      coin_next   = cmp.coin;
      stat_hit    = cmp.irq;
    end else begin
      if (!lcd_was_on) begin
        was_on_next = 1'b1;
        dot_next    = '0;
        line_next   = '0;
        frame_next  = 1'b0;
        if (mode_next != MODE_OAM) begin
          mode_next = MODE_OAM;
          stat_hit  = stat_hit | cfg.stat_int_enables[EN_OAM];
        end
        cmp       = compare_step(line_next, cfg.lyc, coin_next, cfg.stat_int_enables[EN_COINC]);
        coin_next = cmp.coin;
        stat_hit  = stat_hit | cmp.irq;
      end
      if (line_next >= VBLANK_LINE) begin
        nm = MODE_VBLANK;
      end else if (dot_next < OAM_END_DOT) begin
        nm = MODE_OAM;
      end else if (dot_next < XFER_END_DOT) begin
        nm = MODE_XFER;
      end else begin
        nm = MODE_HBLANK;
      end
      if (nm != mode_next) begin
        rs_hit    = (nm == MODE_XFER);
        mode_next = nm;
        stat_hit  = stat_hit | mode_irq(nm, cfg.stat_int_enables);
      end
      cmp       = compare_step(line_next, cfg.lyc, coin_next, cfg.stat_int_enables[EN_COINC]);
      coin_next = cmp.coin;
      stat_hit  = stat_hit | cmp.irq;
      dot_inc   = dot_next + 9'd1;
      if (dot_inc >= DOTS_PER_LINE) begin
        dot_next  = '0;
        line_next = line_next + 8'd1;
        if (line_next == VBLANK_LINE) begin
          mode_next = MODE_VBLANK;
          vbl_hit   = 1'b1;
          stat_hit  = stat_hit | cfg.stat_int_enables[EN_VBLANK];
        end else if (line_next > LAST_LINE) begin
          line_next  = '0;
          frame_next = 1'b1;
        end
        cmp       = compare_step(line_next, cfg.lyc, coin_next, cfg.stat_int_enables[EN_COINC]);
        coin_next = cmp.coin;
        stat_hit  = stat_hit | cmp.irq;
      end else begin
        dot_next = dot_inc;
      end
    end
  end

  assign q_ready  = (state == ST_IDLE);
  assign out_free = !out_valid || out_ch.ready;
  assign busy     = (state != ST_IDLE) || q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      dot_count        <= '0;
      line_count       <= '0;
      current_mode     <= MODE_HBLANK;
      coincidence_flag <= 1'b0;
      lcd_was_on       <= 1'b0;
      frame_flag       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.clear_frame) begin
              frame_flag <= 1'b0;
            end
            state <= (q_item.dots == '0) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          dot_count        <= dot_next;
          line_count       <= line_next;
          current_mode     <= mode_next;
          coincidence_flag <= coin_next;
          lcd_was_on       <= was_on_next;
          frame_flag       <= frame_next;
          if (dots_left == 6'd1) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dots_left  <= q_item.dots;
        irq_stat   <= 1'b0;
        irq_vblank <= 1'b0;
        rstart     <= 1'b0;
        rline      <= '0;
      end
      ST_RUN: begin
        dots_left  <= dots_left - 6'd1;
        irq_stat   <= irq_stat | stat_hit;
        irq_vblank <= irq_vblank | vbl_hit;
        rstart     <= rstart | rs_hit;
        if (rs_hit) begin
          rline <= line_next;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_line  <= line_count;
          out_mode  <= current_mode;
          out_coin  <= coincidence_flag;
          out_vbl   <= irq_vblank;
          out_stat  <= irq_stat;
          out_rs    <= rstart;
          out_rl    <= rline;
          out_frame <= frame_flag;
        end
      end
      default: dots_left <= dots_left;
    endcase
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.line         = out_line;
  assign out_ch.mode_out     = out_mode;
  assign out_ch.coincidence  = out_coin;
  assign out_ch.vblank_irq   = out_vbl;
  assign out_ch.stat_irq     = out_stat;
  assign out_ch.render_start = out_rs;
  assign out_ch.render_line  = out_rl;
  assign out_ch.frame_done   = out_frame;

endmodule

`default_nettype wire

FILE: design/lcdt_cfg.sv
// ----------------------------------------------------------------------------
// lcdt_cfg
// APB register file: display enable, line compare, status interrupt enables.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdt_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [lcdt_pkg::AddrW-1:0] paddr,
  input  wire logic [lcdt_pkg::DataW-1:0] pwdata,
  output logic [lcdt_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output lcdt_pkg::cfg_t                cfg
);
  import lcdt_pkg::*;

  logic       lcd_enable;
  logic [7:0] lyc;
  logic [3:0] stat_int_enables;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_enable       <= 1'b0;
      lyc              <= '0;
      stat_int_enables <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LCD_ENABLE: lcd_enable       <= pwdata[0];
        REG_LYC:        lyc              <= pwdata[7:0];
        REG_STAT_EN:    stat_int_enables <= pwdata[3:0];
        default:        lcd_enable       <= lcd_enable;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LCD_ENABLE: prdata = {31'b0, lcd_enable};
      REG_LYC:        prdata = {24'b0, lyc};
      REG_STAT_EN:    prdata = {28'b0, stat_int_enables};
      default:        prdata = '0;
    endcase
  end

  assign cfg = '{lcd_enable: lcd_enable, lyc: lyc, stat_int_enables: stat_int_enables};

endmodule

`default_nettype wire
